>>> hdl/button_press_command_sender_top_macros.svh
// Assertion macros used by the checker file.
`ifndef BUTTON_PRESS_COMMAND_SENDER_TOP_MACROS_SVH
`define BUTTON_PRESS_COMMAND_SENDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bpcs_pkg.sv
package bpcs_pkg;

	localparam int HISTORY_BITS = 32;
	localparam int COMMAND_BITS = 10;
	localparam int BL_W = $clog2(COMMAND_BITS + 1);

	localparam int MS_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CMD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_CMD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_CMD = 3'd4;

	localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd2000;
	localparam logic [MS_W-1:0] STARTUP_DELAY_RST = 16'd100;
	localparam logic [COMMAND_BITS-1:0] INIT_CMD_RST = COMMAND_BITS'(10'h084);
	localparam logic [COMMAND_BITS-1:0] PAIR_CMD_RST = COMMAND_BITS'(10'h004);
	localparam logic [COMMAND_BITS-1:0] OFF_CMD_RST = COMMAND_BITS'(10'h009);

	localparam logic [MS_W-1:0] MS_MAX = '1;
	localparam logic [HISTORY_BITS-1:0] HIST_ONES = '1;
	localparam logic [HISTORY_BITS-1:0] HIST_ZERO = '0;
	localparam logic [HISTORY_BITS-1:0] HIST_SLEEP = {{(HISTORY_BITS-1){1'b1}}, 1'b0};
	localparam logic [BL_W-1:0] BITS_FULL = BL_W'(COMMAND_BITS);

	typedef enum logic [2:0] {
		PH_STARTUP = 3'd0,
		PH_SEND_INIT = 3'd1,
		PH_ASLEEP = 3'd2,
		PH_AWAKE = 3'd3,
		PH_SEND_PAIR = 3'd4,
		PH_SEND_OFF = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CW_FIRST_HIGH = 2'd0,
		CW_WAIT_LOW = 2'd1,
		CW_WAIT_HIGH = 2'd2
	} clk_wait_t;

	typedef struct packed {
		logic [MS_W-1:0] long_press_ms;
		logic [MS_W-1:0] startup_delay_ms;
		logic [COMMAND_BITS-1:0] init_command;
		logic [COMMAND_BITS-1:0] pair_command;
		logic [COMMAND_BITS-1:0] off_command;
	} cfg_t;

	typedef struct packed {
		logic module_clock;
		logic button_level;
		logic ms_tick;
	} item_t;

	typedef struct packed {
		logic asleep;
		logic busy_sending;
		logic data_bit;
		logic data_drive;
	} result_t;

endpackage

>>> hdl/bpcs_cfg_regs.sv
module bpcs_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [bpcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output bpcs_pkg::cfg_t cfg
);

	bpcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms <= bpcs_pkg::LONG_PRESS_RST;
			cfg_q.startup_delay_ms <= bpcs_pkg::STARTUP_DELAY_RST;
			cfg_q.init_command <= bpcs_pkg::INIT_CMD_RST;
			cfg_q.pair_command <= bpcs_pkg::PAIR_CMD_RST;
			cfg_q.off_command <= bpcs_pkg::OFF_CMD_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				bpcs_pkg::REG_LONG_PRESS: begin
					cfg_q.long_press_ms <= cfg_wdata[bpcs_pkg::MS_W-1:0];
				end
				bpcs_pkg::REG_STARTUP_DELAY: begin
					cfg_q.startup_delay_ms <= cfg_wdata[bpcs_pkg::MS_W-1:0];
				end
				bpcs_pkg::REG_INIT_CMD: begin
					cfg_q.init_command <= cfg_wdata[bpcs_pkg::COMMAND_BITS-1:0];
				end
				bpcs_pkg::REG_PAIR_CMD: begin
					cfg_q.pair_command <= cfg_wdata[bpcs_pkg::COMMAND_BITS-1:0];
				end
				bpcs_pkg::REG_OFF_CMD: begin
					cfg_q.off_command <= cfg_wdata[bpcs_pkg::COMMAND_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/bpcs_engine.sv
module bpcs_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  bpcs_pkg::item_t item,
	input  bpcs_pkg::cfg_t cfg,
	output bpcs_pkg::result_t result
);

	bpcs_pkg::phase_t phase_q, phase_n;
	logic [bpcs_pkg::HISTORY_BITS-1:0] hist_q, hist_n;
	logic [bpcs_pkg::MS_W-1:0] held_q, held_n;
	logic long_q, long_n;
	logic [bpcs_pkg::COMMAND_BITS-1:0] cmd_q, cmd_n;
	logic [bpcs_pkg::BL_W-1:0] bits_q, bits_n;
	bpcs_pkg::clk_wait_t cw_q, cw_n;
	logic [bpcs_pkg::MS_W-1:0] start_q, start_n;

	always_comb begin
		logic send_done;
		phase_n = phase_q;
		hist_n = hist_q;
		held_n = held_q;
		long_n = long_q;
		cmd_n = cmd_q;
		bits_n = bits_q;
		cw_n = cw_q;
		start_n = start_q;
		send_done = 1'b0;

		if (phase_q == bpcs_pkg::PH_STARTUP || phase_q == bpcs_pkg::PH_SEND_INIT) begin
			if (item.ms_tick && start_q != bpcs_pkg::MS_MAX) begin
				start_n = start_q + 1'b1;
			end
		end else if (phase_q != bpcs_pkg::PH_ASLEEP) begin
			if (item.ms_tick) begin
				hist_n = {hist_q[bpcs_pkg::HISTORY_BITS-2:0], item.button_level};
				if (held_q != bpcs_pkg::MS_MAX) begin
					held_n = held_q + 1'b1;
				end
			end
		end

		case (cw_q)
			bpcs_pkg::CW_FIRST_HIGH: begin
				if (item.module_clock) cw_n = bpcs_pkg::CW_WAIT_LOW;
			end
			bpcs_pkg::CW_WAIT_LOW: begin
				if (!item.module_clock) cw_n = bpcs_pkg::CW_WAIT_HIGH;
			end
			default: begin
				if (item.module_clock) begin
					if (bits_q != '0) bits_n = bits_q - 1'b1;
					if (bits_n == '0) begin
						send_done = 1'b1;
					end else begin
						cw_n = bpcs_pkg::CW_WAIT_LOW;
					end
				end
			end
		endcase
		if (!(phase_q inside {bpcs_pkg::PH_SEND_INIT, bpcs_pkg::PH_SEND_PAIR,
				bpcs_pkg::PH_SEND_OFF})) begin
			bits_n = bits_q;
			cw_n = cw_q;
			send_done = 1'b0;
		end

		case (phase_q)
			bpcs_pkg::PH_STARTUP: begin
				if (start_n >= cfg.startup_delay_ms) begin
					phase_n = bpcs_pkg::PH_SEND_INIT;
					cmd_n = cfg.init_command;
					bits_n = bpcs_pkg::BITS_FULL;
					cw_n = bpcs_pkg::CW_FIRST_HIGH;
				end
			end
			bpcs_pkg::PH_SEND_INIT, bpcs_pkg::PH_SEND_OFF: begin
				if (send_done) begin
					phase_n = bpcs_pkg::PH_ASLEEP;
					held_n = '0;
					hist_n = bpcs_pkg::HIST_SLEEP;
				end
			end
			bpcs_pkg::PH_ASLEEP: begin
				if (!item.button_level) phase_n = bpcs_pkg::PH_AWAKE;
			end
			bpcs_pkg::PH_AWAKE: begin
				if (!long_q && hist_n == bpcs_pkg::HIST_ZERO) begin
					if (held_n >= cfg.long_press_ms) begin
						long_n = 1'b1;
						phase_n = bpcs_pkg::PH_SEND_PAIR;
						cmd_n = cfg.pair_command;
						bits_n = bpcs_pkg::BITS_FULL;
						cw_n = bpcs_pkg::CW_FIRST_HIGH;
					end
				end else if (hist_n == bpcs_pkg::HIST_ONES) begin
					if (!long_q) begin
						phase_n = bpcs_pkg::PH_SEND_OFF;
						cmd_n = cfg.off_command;
						bits_n = bpcs_pkg::BITS_FULL;
						cw_n = bpcs_pkg::CW_FIRST_HIGH;
					end else begin
						phase_n = bpcs_pkg::PH_ASLEEP;
						held_n = '0;
						hist_n = bpcs_pkg::HIST_SLEEP;
					end
					long_n = 1'b0;
				end
			end
			bpcs_pkg::PH_SEND_PAIR: begin
				if (send_done) phase_n = bpcs_pkg::PH_AWAKE;
			end
			default: begin
				phase_n = bpcs_pkg::PH_STARTUP;
			end
		endcase
	end

	always_comb begin
		logic sending;
		logic [bpcs_pkg::COMMAND_BITS-1:0] shifted;
		sending = phase_n inside {bpcs_pkg::PH_SEND_INIT, bpcs_pkg::PH_SEND_PAIR,
			bpcs_pkg::PH_SEND_OFF};
		shifted = '0;
		if (cw_n == bpcs_pkg::CW_WAIT_HIGH && bits_n != '0) begin
			shifted = cmd_n >> (bits_n - 1'b1);
		end else if (cw_n == bpcs_pkg::CW_WAIT_LOW && bits_n < bpcs_pkg::BITS_FULL) begin
			shifted = cmd_n >> bits_n;
		end
		result.data_drive = sending;
		result.data_bit = sending & shifted[0];
		result.busy_sending = sending;
		result.asleep = (phase_n == bpcs_pkg::PH_ASLEEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpcs_pkg::PH_STARTUP;
			hist_q <= bpcs_pkg::HIST_ONES;
			held_q <= '0;
			long_q <= 1'b0;
			cmd_q <= '0;
			bits_q <= '0;
			cw_q <= bpcs_pkg::CW_FIRST_HIGH;
			start_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hist_q <= hist_n;
			held_q <= held_n;
			long_q <= long_n;
			cmd_q <= cmd_n;
			bits_q <= bits_n;
			cw_q <= cw_n;
			start_q <= start_n;
		end
	end

endmodule

>>> hdl/button_press_command_sender_top.sv
// Data path: a transaction accepted on the slave side is held in an input register; its result
// is captured in a result register and given on the master side.
// Throughput: one transaction per cycle, sustained while the master side is not stalled.
// Reset: arst_n asynchronously clears the valid flags, configuration and engine state to their
// default values, and the block starts in its start-up delay; the data registers are not reset.
module button_press_command_sender_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [bpcs_pkg::IN_TDATA_W-1:0] s_tdata, // ms_tick, button_level, module_clock
	output logic m_tvalid,
	input  logic m_tready,
	output logic [bpcs_pkg::OUT_TDATA_W-1:0] m_tdata, // data_drive, data_bit, busy_sending, asleep
	input  logic cfg_wen,
	input  logic [bpcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	bpcs_pkg::cfg_t cfg;
	bpcs_pkg::item_t item_s1;
	bpcs_pkg::result_t result, result_s2;
	logic valid_s1, valid_s2, advance;

	assign advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) item_s1 <= s_tdata[2:0];
		if (advance) result_s2 <= result;
	end

	bpcs_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	bpcs_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = {(bpcs_pkg::OUT_TDATA_W-4)'(0), result_s2};

endmodule

>>> hdl/bpcs_checker.sv
`include "button_press_command_sender_top_macros.svh"

module bpcs_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [bpcs_pkg::OUT_TDATA_W-1:0] m_tdata
);

	`BPCS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result changed.")
	`BPCS_ASSERT_NOW(a_drive_busy, clk, arst_n, m_tvalid, m_tdata[0] == m_tdata[2], "Data drive and busy differ.")
	`BPCS_ASSERT_NOW(a_bit_released, clk, arst_n, m_tvalid && !m_tdata[0], !m_tdata[1], "Data bit set while released.")
	`BPCS_ASSERT_NOW(a_sleep_idle, clk, arst_n, m_tvalid && m_tdata[3], !m_tdata[2], "Asleep while sending.")

endmodule

bind button_press_command_sender_top bpcs_checker u_bpcs_checker (.*);
